[hdl/bdil_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bdil_pkg: shared types and constants of the 3x3 binary dilation stream
// Frame limits, field widths, register indexes and the job and result
// records that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package bdil_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W        = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 13;

  // Effective sizes after clamping, and the position counters.
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int OUT_DEPTH   = 2;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);
  localparam int OCC_W       = $clog2(OUT_DEPTH + 1);

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

  typedef logic [PIX_W-1:0] pix_t;

  localparam pix_t PIX_FULL   = 8'd255;
  localparam pix_t PIX_TARGET = 8'd0;

  // One classified pixel handed from the front end to the back end.
  typedef struct packed {
    pix_t             pix;
    logic [COL_W-1:0] addr;
    logic             top_en;
    logic             mid_en;
    logic             emit;
    logic             row_first;
    logic             row_last;
    logic             col_first;
    logic             col_last;
    logic             last;
  } job_t;

  typedef struct packed {
    pix_t pixel;
    logic last;
  } result_t;

endpackage
`default_nettype wire

[hdl/bdil_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bdil_if: stream channels of the 3x3 binary dilation block
// Pixel input, result output and configuration write channels, each with a
// valid/ready handshake and a source and a sink view.
// ----------------------------------------------------------------------------
interface bdil_pix_if import bdil_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_in;
  logic is_pad;

  modport source (output valid, output pixel_in, output is_pad, input ready);
  modport sink (input valid, input pixel_in, input is_pad, output ready);
endinterface

interface bdil_res_if import bdil_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface bdil_cfg_if import bdil_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/bdil_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bdil_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data. A read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module bdil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hdl/bdil_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bdil_front: pixel intake and classification
// Holds the frame size registers and the raster position, drops pads inside
// the frame, turns flush items into zero pixels and tags each job with its
// row buffer address, output and border flags and the end of frame.
// ----------------------------------------------------------------------------
module bdil_front import bdil_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  bdil_pix_if.sink   pixels,
  bdil_cfg_if.sink   cfg,
  output job_t       job,
  output logic       job_valid,
  input  wire logic  job_ready,
  output logic       restart
);

  logic [WEFF_W-1:0] width;
  logic [HEFF_W-1:0] height;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;

  logic [WEFF_W-1:0]       width_next;
  logic [HEFF_W-1:0]       height_next;
  logic [WIDTH_REG_W-1:0]  raw_width;
  logic [HEIGHT_REG_W-1:0] raw_height;
  logic [ROW_W-1:0]        row_h;
  logic [ROW_W-1:0]        row_h1;
  logic [WEFF_W-1:0]       col_inc;
  logic                    flushing;
  logic                    col_zero;
  logic                    take;
  logic                    cfg_take;

  assign cfg.ready    = 1'b1;
  assign pixels.ready = job_ready;

  assign raw_width  = cfg.data[WIDTH_REG_W-1:0];
  assign raw_height = cfg.data[HEIGHT_REG_W-1:0];

  // Zero sizes count as one, oversize values saturate at the maximum.
  always_comb begin
    if (raw_width == '0) begin
      width_next = WEFF_W'(1);
    end else if (32'(raw_width) > MAX_WIDTH) begin
      width_next = WEFF_W'(MAX_WIDTH);
    end else begin
      width_next = WEFF_W'(raw_width);
    end
    if (raw_height == '0) begin
      height_next = HEFF_W'(1);
    end else if (32'(raw_height) > MAX_HEIGHT) begin
      height_next = HEFF_W'(MAX_HEIGHT);
    end else begin
      height_next = HEFF_W'(raw_height);
    end
  end

  assign cfg_take = cfg.valid && cfg.ready &&
                    (cfg.index == REG_FRAME_WIDTH || cfg.index == REG_FRAME_HEIGHT);
  assign restart  = cfg_take;

  assign row_h    = ROW_W'(height);
  assign row_h1   = row_h + ROW_W'(1);
  assign flushing = row >= row_h;
  assign col_zero = col == '0;
  assign col_inc  = WEFF_W'(col) + WEFF_W'(1);

  // Rows at or past the frame height are flush rows: their items carry zero.
  always_comb begin
    job.pix       = flushing ? PIX_TARGET : pixels.pixel_in;
    job.addr      = col;
    job.top_en    = row >= ROW_W'(2);
    job.mid_en    = row != '0;
    job.emit      = (row >= ROW_W'(2)) || (row == ROW_W'(1) && !col_zero);
    job.row_first = (!col_zero && row == ROW_W'(1)) || (col_zero && row == ROW_W'(2));
    job.row_last  = (!col_zero && row == row_h) || (col_zero && row == row_h1);
    job.col_first = (col == COL_W'(1)) || (col_zero && width == WEFF_W'(1));
    job.col_last  = col_zero;
    job.last      = col_zero && row == row_h1;
  end

  assign job_valid = pixels.valid && (flushing || !pixels.is_pad);
  assign take      = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WEFF_W'(RESET_WIDTH);
      height <= HEFF_W'(RESET_HEIGHT);
      col    <= '0;
      row    <= '0;
    end else if (cfg_take) begin
      if (cfg.index == REG_FRAME_WIDTH) begin
        width <= width_next;
      end else begin
        height <= height_next;
      end
      col <= '0;
      row <= '0;
    end else if (take) begin
      if (job.last) begin
        col <= '0;
        row <= '0;
      end else if (col_inc == width) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/bdil_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bdil_queue: short job queue between front end and back end
// A small register FIFO that lets intake and processing stall apart.
// ----------------------------------------------------------------------------
module bdil_queue import bdil_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire job_t  push_data,
  input  wire logic  push_valid,
  output logic       push_ready,
  output job_t       pop_data,
  output logic       pop_valid,
  input  wire logic  pop_ready
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

endmodule
`default_nettype wire

[hdl/bdil_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bdil_back: row buffers, window and dilation
// Reads the two row buffers for each job, shifts the 3x3 window, applies the
// dilation rule at the window center and holds results in a two-entry
// output buffer. Jobs are taken only when the buffer has room for them.
// ----------------------------------------------------------------------------
module bdil_back import bdil_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire job_t  job,
  input  wire logic  job_valid,
  output logic       job_ready,
  input  wire logic  restart,
  bdil_res_if.source results
);

  logic [2:0][2:0][PIX_W-1:0] wnd;
  logic [2:0][2:0][PIX_W-1:0] wnd_next;

  job_t              s1;
  logic              s1_valid;
  logic              byp;
  pix_t              fwd_top;
  pix_t              fwd_mid;
  pix_t              top_rd;
  pix_t              mid_rd;
  pix_t              top_val;
  pix_t              mid_val;
  pix_t              center;
  pix_t              res_pix;
  logic              hit;
  logic [2:0]        row_ok;
  logic [2:0]        col_ok;

  result_t           obuf [OUT_DEPTH];
  logic [OPTR_W-1:0] owr_ptr;
  logic [OPTR_W-1:0] ord_ptr;
  logic [OCC_W-1:0]  occ;
  logic [OCC_W:0]    load;
  logic              drain;
  logic              opush;
  logic              pop;

  // A job is taken only if its result is sure to find a buffer slot.
  assign drain     = results.valid && results.ready;
  assign load      = (OCC_W + 1)'(occ) + (OCC_W + 1)'(s1_valid);
  assign job_ready = load < (OCC_W + 1)'(OUT_DEPTH) + (OCC_W + 1)'(drain);
  assign pop       = job_valid && job_ready;

  bdil_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) top_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1.addr),
    .wr_data (mid_val),
    .rd_en   (pop),
    .rd_addr (job.addr),
    .rd_data (top_rd)
  );

  bdil_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) mid_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1.addr),
    .wr_data (s1.pix),
    .rd_en   (pop),
    .rd_addr (job.addr),
    .rd_data (mid_rd)
  );

  // With a one-pixel row the next read hits the address being written, so
  // the written values are forwarded.
  assign top_val = s1.top_en ? (byp ? fwd_top : top_rd) : PIX_TARGET;
  assign mid_val = s1.mid_en ? (byp ? fwd_mid : mid_rd) : PIX_TARGET;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      wnd_next[r][0] = wnd[r][1];
      wnd_next[r][1] = wnd[r][2];
    end
    wnd_next[0][2] = top_val;
    wnd_next[1][2] = mid_val;
    wnd_next[2][2] = s1.pix;
  end

  assign row_ok = {!s1.row_last, 1'b1, !s1.row_first};
  assign col_ok = {!s1.col_last, 1'b1, !s1.col_first};
  assign center = wnd_next[1][1];

  always_comb begin
    hit = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c] && !(r == 1 && c == 1) &&
            wnd_next[r][c] == PIX_FULL) begin
          hit = 1'b1;
        end
      end
    end
    res_pix = (center == PIX_TARGET && hit) ? PIX_FULL : center;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1 <= job;
    end
    fwd_top <= mid_val;
    fwd_mid <= s1.pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp      <= 1'b0;
      wnd      <= '0;
    end else begin
      s1_valid <= pop;
      byp      <= pop && s1_valid && s1.addr == job.addr;
      if (restart) begin
        wnd <= '0;
      end else if (s1_valid) begin
        wnd <= s1.last ? '0 : wnd_next;
      end
    end
  end

  assign opush              = s1_valid && s1.emit;
  assign results.valid      = occ != '0;
  assign results.pixel_out  = obuf[ord_ptr].pixel;
  assign results.frame_last = obuf[ord_ptr].last;

  always_ff @(posedge clk) begin
    if (opush) begin
      obuf[owr_ptr] <= '{pixel: res_pix, last: s1.last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      occ     <= '0;
    end else begin
      if (opush) begin
        owr_ptr <= owr_ptr + OPTR_W'(1);
      end
      if (drain) begin
        ord_ptr <= ord_ptr + OPTR_W'(1);
      end
      occ <= occ + OCC_W'(opush) - OCC_W'(drain);
    end
  end

`ifndef SYNTHESIS
  a_credit : assert property (@(posedge clk) disable iff (rst)
    load <= (OCC_W + 1)'(OUT_DEPTH))
    else $error("output buffer overcommitted");

  a_pipe : assert property (@(posedge clk) disable iff (rst)
    pop |=> s1_valid)
    else $error("taken job did not reach the window stage");

  a_last_emits : assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.last |-> s1.emit)
    else $error("end of frame job without a result");

  a_frame_clear : assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.last |=> wnd == '0)
    else $error("window not cleared after end of frame");
`endif

endmodule
`default_nettype wire

[hdl/binary_dilate_3x3_stream.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// binary_dilate_3x3_stream: 3x3 binary dilation over a raster pixel stream
// Each zero pixel becomes 255 when any in-frame neighbor is 255; the output
// trails the input by one row plus one pixel and ends with a flagged pixel.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle sustained while results are not held
// back, set by the single read and write port of each row buffer, which
// is used once per pixel. A request that completes a result passes the
// queue, then the row buffer read, window and dilation, then the output buffer.
// Reset is synchronous: positions, queue, window and output buffer clear,
// and the frame size returns to 640 x 480. The row buffers keep their
// contents, since they are read only where the current frame has written.
// ----------------------------------------------------------------------------
module binary_dilate_3x3_stream import bdil_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  bdil_pix_if.sink   pixels,
  bdil_res_if.source results,
  bdil_cfg_if.sink   cfg
);

  // The front end owns the frame size registers and the raster position.
  // It drops pads that arrive inside the frame, turns any request in the
  // flush rows into a zero pixel, and tags each job with everything the
  // back end needs to know about its place in the frame.
  job_t front_job;
  logic front_valid;
  logic front_ready;
  logic restart;

  // Jobs waiting for the back end.
  job_t queue_job;
  logic queue_valid;
  logic queue_ready;

  bdil_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .cfg       (cfg),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .restart   (restart)
  );

  // The queue lets intake keep running while the result side is stalled,
  // and lets the back end drain while no new pixels arrive.
  bdil_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (queue_job),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready)
  );

  // The back end reads the two row buffers, slides the window one column
  // and evaluates the dilation at the window center. Its output buffer
  // decouples the result handshake from the window pipeline.
  bdil_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (queue_job),
    .job_valid (queue_valid),
    .job_ready (queue_ready),
    .restart   (restart),
    .results   (results)
  );

endmodule
`default_nettype wire
